// File: src/focl_pkg.sv
// ----------------------------------------------------------------------------
// focl_pkg
// Shared types, constants and the CORDIC arctangent table for the FOC
// current loop front end.
// ----------------------------------------------------------------------------
`default_nettype none

package focl_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_D_PROP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_D_INT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Q_PROP = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Q_INT  = 2'd3;
  localparam logic [15:0] GAIN_RESET = 16'd4096;

  // Shared multiplier geometry
  localparam int MUL_A_W = 27;
  localparam int MUL_B_W = 33;
  localparam int PROD_W  = 60;

  // Fixed-point constants
  localparam int ATAN_COUNT = 26;
  localparam logic signed [32:0] CORDIC_ONE = 33'sd652032874;
  localparam logic signed [MUL_B_W-1:0] INV_SQRT3_Q16 = 33'sd37837;
  localparam logic signed [MUL_B_W-1:0] MS_Q40 = 33'sd1099511628;
  localparam logic signed [33:0] INT_LIMIT = 34'sd1073741824;
  localparam logic signed [PROD_W-1:0] OUT_LIMIT = 60'sd16384;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT,
    ST_MUL,
    ST_ACC,
    ST_OUT
  } state_t;

  // Multiply-accumulate steps, in issue order
  typedef enum logic [3:0] {
    OP_BETA,
    OP_AC,
    OP_BS,
    OP_BC,
    OP_AS,
    OP_DI,
    OP_DP,
    OP_DK,
    OP_QI,
    OP_QP,
    OP_QK
  } op_t;

  // atan(2^-i) with 2^32 counts per turn
  function automatic logic signed [31:0] atan_val(input logic [4:0] i);
    logic signed [31:0] v;
    begin
      unique case (i)
        5'd0:  v = 32'sd536870912;
        5'd1:  v = 32'sd316933406;
        5'd2:  v = 32'sd167458907;
        5'd3:  v = 32'sd85004756;
        5'd4:  v = 32'sd42667331;
        5'd5:  v = 32'sd21354465;
        5'd6:  v = 32'sd10680862;
        5'd7:  v = 32'sd5340245;
        5'd8:  v = 32'sd2670163;
        5'd9:  v = 32'sd1335087;
        5'd10: v = 32'sd667544;
        5'd11: v = 32'sd333772;
        5'd12: v = 32'sd166886;
        5'd13: v = 32'sd83443;
        5'd14: v = 32'sd41721;
        5'd15: v = 32'sd20860;
        5'd16: v = 32'sd10430;
        5'd17: v = 32'sd5215;
        5'd18: v = 32'sd2607;
        5'd19: v = 32'sd1303;
        5'd20: v = 32'sd651;
        5'd21: v = 32'sd325;
        5'd22: v = 32'sd162;
        5'd23: v = 32'sd81;
        5'd24: v = 32'sd40;
        5'd25: v = 32'sd20;
        default: v = 32'sd0;
      endcase
      return v;
    end
  endfunction

endpackage

`default_nettype wire

// File: src/focl_cordic.sv
// ----------------------------------------------------------------------------
// focl_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, with
// quadrant folding and rounding of sin and cos to TRIG_BITS-2 fraction bits.
// ----------------------------------------------------------------------------
`default_nettype none

module focl_cordic
  import focl_pkg::*;
#(
  parameter int ANGLE_BITS = 16,
  parameter int TRIG_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [15:0]                 angle,
  output logic                        done,
  output logic signed [TRIG_BITS-1:0] sin_val,
  output logic signed [TRIG_BITS-1:0] cos_val
);

  localparam int STEPS = (TRIG_BITS + 2 < ATAN_COUNT) ? TRIG_BITS + 2 : ATAN_COUNT;
  localparam int CNT_W = $clog2(STEPS + 1);
  localparam int CLR   = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
  localparam int SH    = 32 - TRIG_BITS;

  logic                    busy;
  logic [CNT_W-1:0]        cnt;
  logic [1:0]              quad;
  logic signed [32:0]      x;
  logic signed [32:0]      y;
  logic signed [31:0]      z;
  logic [15:0]             ang_m;
  logic signed [32:0]      dx;
  logic signed [32:0]      dy;
  logic signed [31:0]      atan;
  logic signed [32:0]      x_rnd;
  logic signed [32:0]      y_rnd;
  logic signed [TRIG_BITS-1:0] cs;
  logic signed [TRIG_BITS-1:0] sn;
  logic signed [TRIG_BITS-1:0] sin_next;
  logic signed [TRIG_BITS-1:0] cos_next;

  // Drop angle bits below the configured resolution
  assign ang_m = (angle >> CLR) << CLR;

  // Shift-add terms for the current step
  assign dx   = y >>> cnt;
  assign dy   = x >>> cnt;
  assign atan = atan_val(5'(cnt));

  // Round half up to the output precision
  assign x_rnd = (x + (33'sd1 <<< (SH - 1))) >>> SH;
  assign y_rnd = (y + (33'sd1 <<< (SH - 1))) >>> SH;
  assign cs    = TRIG_BITS'(x_rnd);
  assign sn    = TRIG_BITS'(y_rnd);

  // Fold the first-quadrant result into the full turn
  always_comb begin
    case (quad)
      2'd0: begin
        cos_next = cs;
        sin_next = sn;
      end
      2'd1: begin
        cos_next = -sn;
        sin_next = cs;
      end
      2'd2: begin
        cos_next = -cs;
        sin_next = -sn;
      end
      default: begin
        cos_next = sn;
        sin_next = -cs;
      end
    endcase
  end

  // Control: start, iterate, finish
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(STEPS)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: micro-rotations and result capture
  always_ff @(posedge clk) begin
    if (start) begin
      cnt  <= '0;
      x    <= CORDIC_ONE;
      y    <= '0;
      z    <= signed'({2'b00, ang_m[13:0], 16'h0000});
      quad <= ang_m[15:14];
    end else if (busy) begin
      if (cnt == CNT_W'(STEPS)) begin
        sin_val <= sin_next;
        cos_val <= cos_next;
      end else begin
        cnt <= cnt + 1'b1;
        if (z >= 0) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - atan;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + atan;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: src/focl_mac.sv
// ----------------------------------------------------------------------------
// focl_mac
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module focl_mac
  import focl_pkg::*;
(
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [PROD_W-1:0]  prod
);

  // Register the product
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(a * b);
    end
  end

endmodule

`default_nettype wire

// File: src/foc_current_loop_front_end.sv
// ----------------------------------------------------------------------------
// foc_current_loop_front_end
// Clarke and Park transforms plus d and q PI current controllers.
// ----------------------------------------------------------------------------
// One word in gives one word out. A new word is taken only once the
// previous one has been handed to the output register. A word passes
// through the accepting cycle, TRIG_BITS + 2 CORDIC micro-rotations (at
// most ATAN_COUNT), the capture of sin and cos, the exit from the rotation
// step, eleven multiplies through the one shared multiplier, each a
// multiply state and an accumulate state, and the hand-off of the result
// to the output register. The input stalls while a word is in work; a
// finished result waits in the output register while the next word is
// taken. If the previous result is still stalled there, the new one waits
// in the sequencer and the input stays stalled.
`default_nettype none

module foc_current_loop_front_end
  import focl_pkg::*;
#(
  parameter int ANGLE_BITS = 16,
  parameter int TRIG_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [15:0]   phase_a_current,
  input  logic signed [15:0]   phase_b_current,
  input  logic [15:0]          rotor_angle,
  input  logic signed [15:0]   d_current_target,
  input  logic signed [15:0]   q_current_target,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [15:0]   d_voltage_cmd,
  output logic signed [15:0]   q_voltage_cmd,
  output logic signed [15:0]   d_current_measured,
  output logic signed [15:0]   q_current_measured
);

  localparam int SH_MEAS = TRIG_BITS + 6;

  state_t state;
  state_t state_next;
  op_t    op;

  logic in_accept;
  logic out_load;
  logic mul_en;
  logic cordic_done;
  logic signed [TRIG_BITS-1:0] sn;
  logic signed [TRIG_BITS-1:0] cs;

  logic [15:0] d_prop_gain;
  logic [15:0] d_int_gain;
  logic [15:0] q_prop_gain;
  logic [15:0] q_int_gain;
  logic signed [31:0] d_integral;
  logic signed [31:0] q_integral;

  logic signed [15:0] a_r;
  logic signed [15:0] b_r;
  logic signed [15:0] dt_r;
  logic signed [15:0] qt_r;
  logic signed [24:0] beta;
  logic signed [PROD_W-1:0] acc;
  logic signed [16:0] ed;
  logic signed [16:0] eq;
  logic signed [15:0] dm;
  logic signed [15:0] qm;
  logic signed [15:0] vd;
  logic signed [15:0] vq;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [17:0]        ab2;

  logic signed [PROD_W-1:0] sum_add;
  logic signed [PROD_W-1:0] sum_sub;
  logic signed [PROD_W-1:0] meas_src;
  logic signed [PROD_W-1:0] meas_rnd;
  logic signed [15:0]       meas_sat;
  logic signed [16:0]       err;
  logic signed [PROD_W-1:0] istep;
  logic signed [31:0]       int_src;
  logic signed [33:0]       int_sum;
  logic signed [31:0]       int_clamped;
  logic signed [PROD_W-1:0] out_rnd;
  logic signed [15:0]       out_clamped;

  assign in_accept = in_valid && !in_stall;

  // Sine and cosine of the rotor angle
  focl_cordic #(
    .ANGLE_BITS(ANGLE_BITS),
    .TRIG_BITS (TRIG_BITS)
  ) u_cordic (
    .clk    (clk),
    .rst    (rst),
    .start  (in_accept),
    .angle  (rotor_angle),
    .done   (cordic_done),
    .sin_val(sn),
    .cos_val(cs)
  );

  // Shared multiplier
  focl_mac u_mac (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .prod(prod)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_ROT;
      ST_ROT:  if (cordic_done) state_next = ST_MUL;
      ST_MUL:  state_next = ST_ACC;
      ST_ACC:  if (op == OP_QK) state_next = ST_OUT;
               else state_next = ST_MUL;
      ST_OUT:  if (!out_valid || !out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall = (state != ST_IDLE);
    mul_en   = (state == ST_MUL);
    out_load = (state == ST_OUT) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Select multiplier operands for each step
  assign ab2 = 18'(a_r) + (18'(b_r) <<< 1);

  always_comb begin
    case (op)
      OP_BETA: begin
        mul_a = MUL_A_W'(ab2);
        mul_b = INV_SQRT3_Q16;
      end
      OP_AC: begin
        mul_a = MUL_A_W'(a_r);
        mul_b = MUL_B_W'(cs);
      end
      OP_BS: begin
        mul_a = MUL_A_W'(beta);
        mul_b = MUL_B_W'(sn);
      end
      OP_BC: begin
        mul_a = MUL_A_W'(beta);
        mul_b = MUL_B_W'(cs);
      end
      OP_AS: begin
        mul_a = MUL_A_W'(a_r);
        mul_b = MUL_B_W'(sn);
      end
      OP_DI: begin
        mul_a = MUL_A_W'(ed);
        mul_b = MS_Q40;
      end
      OP_DP: begin
        mul_a = signed'({11'b0, d_prop_gain});
        mul_b = MUL_B_W'(ed);
      end
      OP_DK: begin
        mul_a = signed'({11'b0, d_int_gain});
        mul_b = MUL_B_W'(d_integral);
      end
      OP_QI: begin
        mul_a = MUL_A_W'(eq);
        mul_b = MS_Q40;
      end
      OP_QP: begin
        mul_a = signed'({11'b0, q_prop_gain});
        mul_b = MUL_B_W'(eq);
      end
      OP_QK: begin
        mul_a = signed'({11'b0, q_int_gain});
        mul_b = MUL_B_W'(q_integral);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Measured current: round, saturate, form the error
  assign sum_add  = acc + prod;
  assign sum_sub  = acc - (prod <<< 8);
  assign meas_src = (op == OP_BS) ? sum_add : sum_sub;
  assign meas_rnd = (meas_src + (60'sd1 <<< (SH_MEAS - 1))) >>> SH_MEAS;
  always_comb begin
    if (meas_rnd > 60'sd32767) begin
      meas_sat = 16'sh7fff;
    end else if (meas_rnd < -60'sd32768) begin
      meas_sat = -16'sh8000;
    end else begin
      meas_sat = 16'(meas_rnd);
    end
  end
  assign err = (op == OP_BS) ? (17'(dt_r) - 17'(meas_sat)) : (17'(qt_r) - 17'(meas_sat));

  // Integrator step with clamp
  assign istep   = (prod + 60'sd131072) >>> 18;
  assign int_src = (op == OP_DI) ? d_integral : q_integral;
  assign int_sum = 34'(int_src) + 34'(istep);
  always_comb begin
    if (int_sum > INT_LIMIT) begin
      int_clamped = 32'(INT_LIMIT);
    end else if (int_sum < -INT_LIMIT) begin
      int_clamped = 32'(-INT_LIMIT);
    end else begin
      int_clamped = 32'(int_sum);
    end
  end

  // Controller output: round and clamp
  assign out_rnd = (sum_add + 60'sd134217728) >>> 28;
  always_comb begin
    if (out_rnd > OUT_LIMIT) begin
      out_clamped = 16'(OUT_LIMIT);
    end else if (out_rnd < -OUT_LIMIT) begin
      out_clamped = 16'(-OUT_LIMIT);
    end else begin
      out_clamped = 16'(out_rnd);
    end
  end

  // Configuration registers and integrator state
  always_ff @(posedge clk) begin
    if (rst) begin
      d_prop_gain <= GAIN_RESET;
      d_int_gain  <= GAIN_RESET;
      q_prop_gain <= GAIN_RESET;
      q_int_gain  <= GAIN_RESET;
      d_integral  <= '0;
      q_integral  <= '0;
    end else begin
      if (cfg_write_en) begin
        unique case (cfg_index)
          REG_D_PROP: d_prop_gain <= cfg_data;
          REG_D_INT:  d_int_gain  <= cfg_data;
          REG_Q_PROP: q_prop_gain <= cfg_data;
          REG_Q_INT:  q_int_gain  <= cfg_data;
          default: ;
        endcase
      end
      if (state == ST_ACC && op == OP_DI) d_integral <= int_clamped;
      if (state == ST_ACC && op == OP_QI) q_integral <= int_clamped;
    end
  end

  // Capture the word and advance through the steps
  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_r  <= phase_a_current;
      b_r  <= phase_b_current;
      dt_r <= d_current_target;
      qt_r <= q_current_target;
      op   <= OP_BETA;
    end else if (state == ST_ACC) begin
      if (op != OP_QK) op <= op_t'(op + 4'd1);
      case (op)
        OP_BETA: beta <= 25'((prod + 60'sd128) >>> 8);
        OP_AC:   acc  <= prod <<< 8;
        OP_BS: begin
          dm <= meas_sat;
          ed <= err;
        end
        OP_BC:   acc  <= prod;
        OP_AS: begin
          qm <= meas_sat;
          eq <= err;
        end
        OP_DP:   acc  <= prod <<< 22;
        OP_DK:   vd   <= out_clamped;
        OP_QP:   acc  <= prod <<< 22;
        OP_QK:   vq   <= out_clamped;
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      d_voltage_cmd      <= vd;
      q_voltage_cmd      <= vq;
      d_current_measured <= dm;
      q_current_measured <= qm;
    end
  end

endmodule

`default_nettype wire

// File: src/focl_checker.sv
// ----------------------------------------------------------------------------
// focl_checker
// Port-level checks of the FOC current loop front end, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module focl_checker (
  input wire               clk,
  input wire               rst,
  input wire               in_valid,
  input wire               in_stall,
  input wire               out_valid,
  input wire               out_stall,
  input wire signed [15:0] d_voltage_cmd,
  input wire signed [15:0] q_voltage_cmd
);

  // Reset empties the output register
  a_reset_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word valid after reset");

  // An accepted word makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accepting a word");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(d_voltage_cmd)
      && $stable(q_voltage_cmd))
    else $error("stalled output word changed");

  // Voltage commands stay within plus or minus 16384 (OUT_LIMIT)
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> d_voltage_cmd <= 16'sd16384 && d_voltage_cmd >= -16'sd16384
      && q_voltage_cmd <= 16'sd16384 && q_voltage_cmd >= -16'sd16384)
    else $error("voltage command out of range");

endmodule

bind foc_current_loop_front_end focl_checker u_focl_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .d_voltage_cmd(d_voltage_cmd),
  .q_voltage_cmd(q_voltage_cmd)
);

`default_nettype wire

// File: sim/tb_foc_current_loop_front_end.sv
// ----------------------------------------------------------------------------
// tb_foc_current_loop_front_end
// Self-checking bench for the FOC current loop front end: an internal model
// of the Clarke/Park transforms and both PI loops predicts each result word,
// while random gaps, output stalls and one long hold-off exercise the
// handshakes across several gain settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_foc_current_loop_front_end;
  import focl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ANGLE_BITS = 16;
  localparam int TRIG_BITS  = 16;
  localparam int TRIG_FRAC  = TRIG_BITS - 2;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES = 8;
  localparam int WORDS_PER_PHASE = 240;
  localparam int QUIET_WORDS = 150;

  typedef struct {
    logic signed [15:0] vd;
    logic signed [15:0] vq;
    logic signed [15:0] dm;
    logic signed [15:0] qm;
  } loop_result_t;

  // Predicts the result word for each accepted sample and checks the outputs
  class current_loop_scoreboard;
    logic [15:0] gain [4];
    longint d_acc, q_acc;
    loop_result_t pending [$];
    int mismatches;

    function new();
      reset_state();
    endfunction

    function void reset_state();
      for (int i = 0; i < 4; i++) gain[i] = GAIN_RESET;
      d_acc = 0;
      q_acc = 0;
      mismatches = 0;
    endfunction

    function void set_gain(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
      gain[idx] = val;
    endfunction

    // Add half an LSB, then floor
    function longint round_shift(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function longint clamp(longint v, longint lim_lo, longint lim_hi);
      if (v > lim_hi) return lim_hi;
      if (v < lim_lo) return lim_lo;
      return v;
    endfunction

    // Quadrant fold plus rotation-mode CORDIC
    function void sin_cos(logic [15:0] ang, output longint s, output longint c);
      logic [31:0] ph;
      logic [1:0] quad;
      longint x, y, z, dx, dy, cs, sn;
      ph = {ang, 16'h0000};
      ph &= 32'hFFFF_FFFF << (32 - ANGLE_BITS);
      quad = ph[31:30];
      z = longint'(ph[29:0]);
      x = CORDIC_ONE;
      y = 0;
      for (int i = 0; i < TRIG_BITS + 2 && i < ATAN_COUNT; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(atan_val(i[4:0]));
        end else begin
          x += dx; y -= dy; z += longint'(atan_val(i[4:0]));
        end
      end
      cs = round_shift(x, 30 - TRIG_FRAC);
      sn = round_shift(y, 30 - TRIG_FRAC);
      case (quad)
        2'd0: begin c = cs;  s = sn;  end
        2'd1: begin c = -sn; s = cs;  end
        2'd2: begin c = -cs; s = -sn; end
        default: begin c = sn; s = -cs; end
      endcase
    endfunction

    // One PI update; the integral is held in acc
    function longint pi_update(ref longint acc, input logic [15:0] kp,
                               input logic [15:0] ki, input longint e);
      longint sum;
      acc = clamp(acc + round_shift(e * longint'(MS_Q40), 18),
                  -longint'(INT_LIMIT), longint'(INT_LIMIT));
      sum = longint'(kp) * e * 64'sd4194304 + longint'(ki) * acc;
      return clamp(round_shift(sum, 28), -longint'(OUT_LIMIT), longint'(OUT_LIMIT));
    endfunction

    function void note_input(logic signed [15:0] a, logic signed [15:0] b,
                             logic [15:0] ang, logic signed [15:0] dt,
                             logic signed [15:0] qt);
      longint s, c, alpha, beta, dm, qm;
      loop_result_t r;
      sin_cos(ang, s, c);
      alpha = longint'(a) * 256;
      beta = round_shift((longint'(a) + 2 * longint'(b)) * longint'(INV_SQRT3_Q16), 8);
      dm = clamp(round_shift(alpha * c + beta * s, 8 + TRIG_FRAC), -32768, 32767);
      qm = clamp(round_shift(beta * c - alpha * s, 8 + TRIG_FRAC), -32768, 32767);
      r.vd = 16'(pi_update(d_acc, gain[REG_D_PROP], gain[REG_D_INT], longint'(dt) - dm));
      r.vq = 16'(pi_update(q_acc, gain[REG_Q_PROP], gain[REG_Q_INT], longint'(qt) - qm));
      r.dm = 16'(dm);
      r.qm = 16'(qm);
      pending.push_back(r);
    endfunction

    function void check_result(loop_result_t got);
      loop_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word vd=%0d vq=%0d dm=%0d qm=%0d",
                   got.vd, got.vq, got.dm, got.qm);
        return;
      end
      want = pending.pop_front();
      if (got.vd !== want.vd || got.vq !== want.vq ||
          got.dm !== want.dm || got.qm !== want.qm) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result mismatch: expected vd=%0d vq=%0d dm=%0d qm=%0d, ",
                    "got vd=%0d vq=%0d dm=%0d qm=%0d"},
                   want.vd, want.vq, want.dm, want.qm,
                   got.vd, got.vq, got.dm, got.qm);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] phase_a_current = '0;
  logic signed [15:0] phase_b_current = '0;
  logic [15:0] rotor_angle = '0;
  logic signed [15:0] d_current_target = '0;
  logic signed [15:0] q_current_target = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] d_voltage_cmd, q_voltage_cmd;
  logic signed [15:0] d_current_measured, q_current_measured;

  current_loop_scoreboard loop_board = new();
  bit quiet = 1'b0;
  int words_sent = 0;
  int cycle_count = 0;

  foc_current_loop_front_end #(
    .ANGLE_BITS(ANGLE_BITS),
    .TRIG_BITS (TRIG_BITS)
  ) dut (
    .clk, .rst, .cfg_write_en, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .phase_a_current, .phase_b_current, .rotor_angle,
    .d_current_target, .q_current_target,
    .out_valid, .out_stall, .d_voltage_cmd, .q_voltage_cmd,
    .d_current_measured, .q_current_measured
  );

  always #2 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Check every accepted result word
  always @(posedge clk) begin
    loop_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.vd = d_voltage_cmd;
      got.vq = q_voltage_cmd;
      got.dm = d_current_measured;
      got.qm = q_current_measured;
      loop_board.check_result(got);
    end
  end

  // Stall the output in random bursts; hold off once for a long stretch
  initial begin
    int n;
    bit held;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        out_stall = 1'b0;
      end else if (!held && words_sent >= 60) begin
        held = 1'b1;
        out_stall = 1'b1;
        n = 0;
        while (n < HOLD_CYCLES) begin
          @(negedge clk);
          n++;
        end
        out_stall = 1'b0;
      end else begin
        out_stall = ($urandom_range(0, 3) == 0);
        n = $urandom_range(1, 16);
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  task automatic write_gain(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_write_en = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    loop_board.set_gain(idx, val);
    @(negedge clk);
    cfg_write_en = 1'b0;
  endtask

  // Offer one word and hold it until accepted
  task automatic send_word(logic signed [15:0] a, logic signed [15:0] b,
                           logic [15:0] ang, logic signed [15:0] dt,
                           logic signed [15:0] qt);
    @(negedge clk);
    phase_a_current = a;
    phase_b_current = b;
    rotor_angle = ang;
    d_current_target = dt;
    q_current_target = qt;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    loop_board.note_input(a, b, ang, dt, qt);
    words_sent++;
  endtask

  task automatic idle_gap(int n);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain();
    idle_gap(1);
    while (loop_board.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_random_word();
    logic signed [15:0] a, b, dt, qt;
    a = 16'($urandom);
    b = 16'($urandom);
    dt = 16'($urandom);
    qt = 16'($urandom);
    // Half of the words use small currents so the loops settle instead of pinning
    if ($urandom_range(0, 1) == 0) begin
      a = $signed(a) >>> $urandom_range(4, 10);
      b = $signed(b) >>> $urandom_range(4, 10);
      dt = $signed(dt) >>> $urandom_range(4, 10);
      qt = $signed(qt) >>> $urandom_range(4, 10);
    end
    send_word(a, b, 16'($urandom), dt, qt);
  endtask

  initial begin
    logic [15:0] corner [6];
    corner = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h4000};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: field extremes, quadrant boundaries, saturated feedback
    for (int i = 0; i < 6; i++)
      send_word(corner[i], corner[(i + 1) % 6], corner[(i + 2) % 6],
                corner[(i + 3) % 6], corner[(i + 4) % 6]);
    send_word(16'sh7FFF, 16'sh7FFF, 16'h1555, 16'sh8000, 16'sh8000);
    send_word(16'sh8000, 16'sh8000, 16'h2000, 16'sh7FFF, 16'sh7FFF);
    send_word(16'sh7FFF, 16'sh8000, 16'hE000, 16'sh0000, 16'sh0000);
    for (int q = 0; q < 8; q++)
      send_word(16'sh0100, 16'sh0080, 16'(q * 16'h2000), 16'sh0040, 16'shFFC0);
    send_word(16'sh0000, 16'sh0000, 16'hC000, 16'sh0000, 16'sh0000);
    send_word(16'sh0000, 16'sh0000, 16'h8001, 16'sh7FFF, 16'sh8000);

    // Random phases across gain settings, extremes first
    for (int p = 0; p < PHASES; p++) begin
      drain();
      for (int r = 0; r < 4; r++) begin
        case (p)
          0: write_gain(r[CFG_IDX_W-1:0], 16'hFFFF);
          1: write_gain(r[CFG_IDX_W-1:0], 16'h0000);
          2: write_gain(r[CFG_IDX_W-1:0], GAIN_RESET);
          3: write_gain(r[CFG_IDX_W-1:0], (r % 2) ? 16'h0000 : 16'hFFFF);
          default: write_gain(r[CFG_IDX_W-1:0], 16'($urandom_range(0, 16'h3000)));
        endcase
      end
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        if (p == PHASES - 1 && k >= WORDS_PER_PHASE - QUIET_WORDS) quiet = 1'b1;
        send_random_word();
        if (!quiet && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 16));
      end
    end

    drain();
    if (loop_board.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
src/focl_pkg.sv
src/focl_cordic.sv
src/focl_mac.sv
src/foc_current_loop_front_end.sv
src/focl_checker.sv
sim/tb_foc_current_loop_front_end.sv
